@@ sv/hri_pkg.sv @@
// ----------------------------------------------------------------------------
// hri_pkg
// Widths, step counts and shared types of the radical inverse block.
// ----------------------------------------------------------------------------
package hri_pkg;

	localparam int INDEX_BITS = 31;
	localparam int FRAC_BITS  = 32;
	localparam int BASE_BITS  = 8;

	// a base of at least two gives no more digits than index bits
	localparam int MAX_DIGITS = INDEX_BITS;
	localparam int SLOT_W     = $clog2(MAX_DIGITS);
	localparam int FILL_W     = $clog2(MAX_DIGITS + 1);

	// fraction step divides {digit, acc}, digit step divides the index
	localparam int FNUM_W = BASE_BITS + FRAC_BITS;
	localparam int DIV_W  = (INDEX_BITS > FNUM_W) ? INDEX_BITS : FNUM_W;
	localparam int STEP_W = $clog2(DIV_W + 1);

	localparam logic [STEP_W-1:0] DIG_STEPS  = STEP_W'(INDEX_BITS);
	localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(FNUM_W);

	typedef struct packed {
		logic go;
		logic frac_mode;
	} div_ctl_t;

endpackage

@@ sv/hri_divider.sv @@
// ----------------------------------------------------------------------------
// hri_divider
// Restoring divider, one quotient bit per cycle, shared by both phases.
// ----------------------------------------------------------------------------
module hri_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hri_pkg::div_ctl_t              ctl,
	input  logic [hri_pkg::BASE_BITS-1:0]  divisor,
	input  logic [hri_pkg::DIV_W-1:0]      dividend,
	output logic [hri_pkg::DIV_W-1:0]      quotient,
	output logic [hri_pkg::BASE_BITS-1:0]  remainder,
	output logic                           done
);
	import hri_pkg::*;

	logic [DIV_W-1:0]     q_q;
	logic [BASE_BITS-1:0] rem_q;
	logic [BASE_BITS-1:0] div_q;
	logic [STEP_W-1:0]    cnt_q;
	logic                 done_q;
	logic [BASE_BITS:0]   trial;
	logic [BASE_BITS:0]   diff;
	logic                 qbit;

	assign trial = {rem_q, q_q[DIV_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1));
			if (ctl.go) begin
				cnt_q <= ctl.frac_mode ? FRAC_STEPS : DIG_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			// quotient bits enter at the bottom as dividend bits leave the top
			q_q   <= {q_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
		end
	end

	assign quotient  = q_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

@@ sv/hri_digit_stack.sv @@
// ----------------------------------------------------------------------------
// hri_digit_stack
// Last-in first-out store of index digits, registered read on pop.
// ----------------------------------------------------------------------------
module hri_digit_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           pop,
	input  logic [hri_pkg::BASE_BITS-1:0]  wr_data,
	output logic [hri_pkg::BASE_BITS-1:0]  rd_data,
	output logic                           empty
);
	import hri_pkg::*;

	logic [BASE_BITS-1:0] mem [MAX_DIGITS];
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_dec;
	logic [BASE_BITS-1:0] rd_q;

	assign fill_dec = fill_q - FILL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (pop) begin
			fill_q <= fill_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[fill_q[SLOT_W-1:0]] <= wr_data;
		end
		if (pop) begin
			rd_q <= mem[fill_dec[SLOT_W-1:0]];
		end
	end

	assign rd_data = rd_q;
	assign empty   = (fill_q == '0);

endmodule

@@ sv/halton_radical_inverse.sv @@
// ----------------------------------------------------------------------------
// halton_radical_inverse
// Radical inverse of a sample index in a given base, 0.32 fixed point.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until the result
// strobe. With D base digits in the index, an item takes D digit extractions
// and D fraction steps, all on the one bit-serial divider; a zero index or a
// base below two skips the divider and never raises busy. The result is
// on fraction and bad_base for the single cycle that done is high and must
// be captured then. A new start is taken in that same cycle.
module halton_radical_inverse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [hri_pkg::BASE_BITS-1:0]  base,
	input  logic [hri_pkg::INDEX_BITS-1:0] index,
	output logic                           done,
	output logic [hri_pkg::FRAC_BITS-1:0]  fraction,
	output logic                           bad_base
);
	import hri_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIG   = 5'b00010,
		S_FREAD = 5'b00100,
		S_FLOAD = 5'b01000,
		S_FRAC  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [BASE_BITS-1:0] base_q;
	logic [FRAC_BITS-1:0] acc_q;
	logic [FRAC_BITS-1:0] fraction_q;
	logic                 bad_q;
	logic                 done_q;

	div_ctl_t             dctl;
	logic [BASE_BITS-1:0] divisor;
	logic [DIV_W-1:0]     dividend;
	logic [DIV_W-1:0]     quot;
	logic [BASE_BITS-1:0] rem;
	logic                 div_done;

	logic                 push;
	logic                 pop;
	logic [BASE_BITS-1:0] top_digit;
	logic                 empty;

	logic                  accept;
	logic                  base_ok;
	logic [INDEX_BITS-1:0] n_next;

	assign accept  = start && (state_q == S_IDLE);
	assign base_ok = (base >= BASE_BITS'(2));
	assign n_next  = (state_q == S_IDLE) ? index : quot[INDEX_BITS-1:0];

	always_comb begin
		dctl.go        = 1'b0;
		dctl.frac_mode = 1'b0;
		push           = 1'b0;
		pop            = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				dctl.go = accept && base_ok && (index != '0);
			end
			S_DIG: begin
				push    = div_done;
				dctl.go = div_done && (n_next != '0);
			end
			S_FREAD: begin
				pop = 1'b1;
			end
			S_FLOAD: begin
				dctl.go        = 1'b1;
				dctl.frac_mode = 1'b1;
			end
			S_FRAC: begin
			end
			default: begin
			end
		endcase
	end

	assign divisor  = (state_q == S_IDLE) ? base : base_q;
	assign dividend = dctl.frac_mode
		? (DIV_W'({top_digit, acc_q}) << (DIV_W - FNUM_W))
		: (DIV_W'(n_next) << (DIV_W - INDEX_BITS));

	hri_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dctl),
		.divisor   (divisor),
		.dividend  (dividend),
		.quotient  (quot),
		.remainder (rem),
		.done      (div_done)
	);

	hri_digit_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.wr_data (rem),
		.rd_data (top_digit),
		.empty   (empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!base_ok || (index == '0)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_DIG;
						end
					end
				end
				S_DIG: begin
					// last digit found once the running quotient hits zero
					if (div_done && (n_next == '0)) begin
						state_q <= S_FREAD;
					end
				end
				S_FREAD: begin
					state_q <= S_FLOAD;
				end
				S_FLOAD: begin
					state_q <= S_FRAC;
				end
				S_FRAC: begin
					if (div_done) begin
						if (empty) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_FREAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q     <= base;
			acc_q      <= '0;
			fraction_q <= '0;
			bad_q      <= !base_ok;
		end else if ((state_q == S_FRAC) && div_done) begin
			acc_q      <= quot[FRAC_BITS-1:0];
			fraction_q <= quot[FRAC_BITS-1:0];
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign fraction = fraction_q;
	assign bad_base = bad_q;

endmodule

@@ tb/halton_radical_inverse_tb.sv @@
// ----------------------------------------------------------------------------
// halton_radical_inverse_tb
// Drives base/index beats into the radical inverse block with random gaps.
// A scoreboard predicts each fraction and bad_base flag, then checks every
// done strobe in order against the oldest pending prediction.
// ----------------------------------------------------------------------------

class ri_scoreboard;

	typedef struct {
		logic [hri_pkg::FRAC_BITS-1:0] fraction;
		logic                          bad_base;
	} ri_result_t;

	ri_result_t pending_q[$];
	int         mismatches = 0;

	// mirror the base-b digits of n about the radix point, truncating each step
	function logic [hri_pkg::FRAC_BITS-1:0] mirror(logic [hri_pkg::BASE_BITS-1:0] b,
			logic [hri_pkg::INDEX_BITS-1:0] n);
		logic [63:0] digits[$];
		logic [63:0] rest;
		logic [63:0] acc;
		rest = 64'(n);
		acc  = '0;
		while (rest != 0) begin
			digits.push_back(rest % 64'(b));
			rest = rest / 64'(b);
		end
		// most significant digit first
		while (digits.size() > 0)
			acc = ((digits.pop_back() << hri_pkg::FRAC_BITS) + acc) / 64'(b);
		return acc[hri_pkg::FRAC_BITS-1:0];
	endfunction

	function void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	function void note(logic [hri_pkg::BASE_BITS-1:0] b, logic [hri_pkg::INDEX_BITS-1:0] n);
		ri_result_t r;
		if (b < 2) begin
			r.fraction = '0;
			r.bad_base = 1'b1;
		end else begin
			r.fraction = mirror(b, n);
			r.bad_base = 1'b0;
		end
		pending_q.push_back(r);
	endfunction

	function void check(logic [hri_pkg::FRAC_BITS-1:0] f, logic bad);
		ri_result_t want;
		if (pending_q.size() == 0) begin
			flag($sformatf("mismatch: done with nothing pending (fraction %h bad_base %b)",
				f, bad));
		end else begin
			want = pending_q.pop_front();
			if (want.fraction !== f || want.bad_base !== bad)
				flag($sformatf("mismatch: fraction %h bad_base %b, expected %h %b",
					f, bad, want.fraction, want.bad_base));
		end
	endfunction

	function int pending();
		return pending_q.size();
	endfunction

endclass

module halton_radical_inverse_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hri_pkg::*;

	localparam int N_RANDOM     = 1000;
	localparam int WORST_CYCLES = 75 * INDEX_BITS + 1;
	localparam int DRAIN_CYCLES = WORST_CYCLES + 20;
	localparam int LIMIT_CYCLES = (N_RANDOM + 100) * (WORST_CYCLES + 14) * 3;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [BASE_BITS-1:0]  base;
	logic [INDEX_BITS-1:0] index;
	logic                  done;
	logic [FRAC_BITS-1:0]  fraction;
	logic                  bad_base;

	logic                  took;
	int                    cycles;
	ri_scoreboard          sb;

	halton_radical_inverse DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.base     (base),
		.index    (index),
		.done     (done),
		.fraction (fraction),
		.bad_base (bad_base)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		sb     = new;
		arst_n = 1'b0;
		start  = 1'b0;
		base   = '0;
		index  = '0;
		took   = 1'b0;
		cycles = 0;
	end

	// a beat goes in on start && !busy; results come with done
	always @(posedge clk) begin
		cycles <= cycles + 1;
		took   <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			sb.note(base, index);
		if (arst_n && done)
			sb.check(fraction, bad_base);
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// called at a falling edge once the previous beat is in
	task automatic send_item(input logic [BASE_BITS-1:0] b, input logic [INDEX_BITS-1:0] n,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		base  <= b;
		index <= n;
		do @(negedge clk); while (!took);
	endtask

	function automatic logic [INDEX_BITS-1:0] rand_index();
		logic [31:0] mask;
		mask = (32'd1 << $urandom_range(0, INDEX_BITS)) - 32'd1;
		return INDEX_BITS'($urandom() & mask);
	endfunction

	initial begin
		logic [INDEX_BITS-1:0] full;
		logic [BASE_BITS-1:0]  b;
		logic [INDEX_BITS-1:0] n;
		logic [BASE_BITS-1:0]  primes[11];
		int                    pick;
		int                    gap;
		bit                    no_idle;

		full   = '1;
		primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: invalid bases, zero index, extreme bases and indices
		send_item(0, 0, 0);
		send_item(1, full, 0);
		send_item(0, full, 0);
		send_item(1, 0, 2);
		send_item(2, 0, 0);
		send_item(2, 1, 0);
		send_item(2, full, 1);
		send_item(2, 31'h4000_0000, 0);
		send_item(2, 31'h2aaa_aaaa, 3);
		send_item(3, full, 0);
		send_item(3, 1, 0);
		send_item(255, full, 0);
		send_item(255, 254, 0);
		send_item(255, 255, 0);
		send_item(254, full, 5);
		send_item(128, full, 0);
		send_item(10, 12345, 0);
		send_item(7, 1, 0);
		send_item(5, 4, 0);
		send_item(0, 31'h5555_5555, 0);
		send_item(253, 0, 0);
		send_item(1, 31'h0000_0001, 0);

		no_idle = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				b = BASE_BITS'($urandom_range(0, 1));
				n = INDEX_BITS'($urandom());
			end else if (pick < 20) begin
				b = 2;
				n = ($urandom_range(0, 1) == 0) ? INDEX_BITS'($urandom()) : rand_index();
			end else if (pick < 45) begin
				b = primes[$urandom_range(0, 10)];
				n = INDEX_BITS'($urandom());
			end else if (pick < 55) begin
				b = BASE_BITS'($urandom_range(2, 255));
				n = INDEX_BITS'($urandom_range(0, 300));
			end else begin
				b = BASE_BITS'($urandom());
				n = rand_index();
			end
			if ($urandom_range(0, 39) == 0)
				no_idle = !no_idle;
			gap = no_idle ? 0 : $urandom_range(0, 13);
			send_item(b, n, gap);
		end
		start <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
